### src/cbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // External ROM address width and the widest value it may take
  localparam int ROM_ADDR_BITS = 21;
  localparam int ADDR_W_MAX    = 24;
  localparam int FULL_ADDR_W   = 21;  // 8-bit bank plus 13-bit offset

  localparam int NUM_BANKS     = 4;
  localparam int BANK_W        = 8;
  localparam int BANK_COUNT_W  = 9;
  localparam int ROM_SIZE_W    = 22;
  localparam int TYPE_W        = 3;
  localparam int CFG_INDEX_W   = 2;

  // Mapper types
  localparam logic [TYPE_W-1:0] MT_FLAT   = 3'd0;
  localparam logic [TYPE_W-1:0] MT_KON4   = 3'd1;
  localparam logic [TYPE_W-1:0] MT_ASC8   = 3'd2;
  localparam logic [TYPE_W-1:0] MT_ASC16  = 3'd3;
  localparam logic [TYPE_W-1:0] MT_KONSCC = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_TYPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE    = 2'd1;

  localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = 22'd32768;

  // Bus mode
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // 8K window numbers (address bits 15:13)
  localparam logic [2:0] WIN_KONAMI_1 = 3'(16'h6000 >> 13);
  localparam logic [2:0] WIN_KONAMI_2 = 3'(16'h8000 >> 13);
  localparam logic [2:0] WIN_KONAMI_3 = 3'(16'hA000 >> 13);
  localparam logic [2:0] WIN_FIRST_BANKED = 3'd2;
  localparam logic [2:0] WIN_LAST_BANKED  = 3'd5;

  // 2K slots (address bits 15:11)
  localparam logic [4:0] SLOT_6000 = 5'(16'h6000 >> 11);
  localparam logic [4:0] SLOT_7000 = 5'(16'h7000 >> 11);
  localparam logic [4:0] SLOT_5000 = 5'(16'h5000 >> 11);
  localparam logic [4:0] SLOT_9000 = 5'(16'h9000 >> 11);
  localparam logic [4:0] SLOT_B000 = 5'(16'hB000 >> 11);

  localparam logic [15:0] PLAIN_BASE = 16'h4000;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } cmd_t;

  typedef struct packed {
    logic [ROM_ADDR_BITS-1:0] rom_address;
    logic                     open_bus;
  } result_t;

  typedef struct packed {
    logic        en;
    logic [15:0] address;
    logic [7:0]  data;
  } bank_wr_t;

  typedef struct packed {
    logic              en;
    logic [TYPE_W-1:0] mapper_type;
  } type_load_t;

  typedef logic [NUM_BANKS-1:0][BANK_W-1:0] bank_file_t;

  // Trim or widen a full ROM byte address to the external address width
  function automatic logic [ROM_ADDR_BITS-1:0] fit_rom_addr(
    input logic [FULL_ADDR_W-1:0] full
  );
    logic [ADDR_W_MAX-1:0] wide;
    wide = ADDR_W_MAX'(full);
    return wide[ROM_ADDR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### src/cbm_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module cbm_mod_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [cbm_pkg::BANK_W-1:0]        dividend,
  input  wire logic [cbm_pkg::BANK_COUNT_W-1:0]  divisor,
  output logic                                   done,
  output logic [cbm_pkg::BANK_W-1:0]             remainder
);
  import cbm_pkg::*;

  localparam int STEP_W = $clog2(BANK_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BANK_W - 1);

  logic                    active;
  logic [STEP_W-1:0]       step;
  logic [BANK_W-1:0]       shreg;
  logic [BANK_COUNT_W-1:0] rem;
  logic [BANK_COUNT_W-1:0] dsor;
  logic [BANK_COUNT_W-1:0] trial;
  logic [BANK_COUNT_W-1:0] rem_next;

  always_comb begin
    trial = {rem[BANK_COUNT_W-2:0], shreg[BANK_W-1]};
    if (trial >= dsor) begin
      rem_next = trial - dsor;
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dsor  <= divisor;
    end else if (active) begin
      rem   <= rem_next;
      shreg <= {shreg[BANK_W-2:0], 1'b0};
    end
  end

  // Remainder never exceeds the 8-bit dividend
  assign remainder = rem[BANK_W-1:0];

endmodule

`default_nettype wire

### src/cbm_bank_regs.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank registers for windows 2..5 with per-type write decode and default loads.
module cbm_bank_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [cbm_pkg::TYPE_W-1:0]  mapper_type,
  input  wire cbm_pkg::bank_wr_t           bank_wr,
  input  wire cbm_pkg::type_load_t         type_load,
  output cbm_pkg::bank_file_t              banks
);
  import cbm_pkg::*;

  bank_file_t banks_next;
  logic [7:0] v;
  logic [4:0] slot;
  logic [2:0] win;

  assign v    = bank_wr.data;
  assign slot = bank_wr.address[15:11];
  assign win  = bank_wr.address[15:13];

  always_comb begin
    banks_next = banks;
    if (type_load.en) begin
      banks_next = '0;
      unique case (type_load.mapper_type) inside
        MT_KON4, MT_KONSCC: begin
          banks_next[0] = 8'd0;
          banks_next[1] = 8'd1;
          banks_next[2] = 8'd2;
          banks_next[3] = 8'd3;
        end
        MT_ASC16: begin
          banks_next[1] = 8'd1;
          banks_next[3] = 8'd1;
        end
        default: begin
          banks_next = '0;
        end
      endcase
    end else if (bank_wr.en) begin
      unique case (mapper_type)
        MT_KON4: begin
          if (win == WIN_KONAMI_1) begin
            banks_next[1] = v;
          end else if (win == WIN_KONAMI_2) begin
            banks_next[2] = v;
          end else if (win == WIN_KONAMI_3) begin
            banks_next[3] = v;
          end
        end
        MT_ASC8: begin
          if (slot[4:2] == SLOT_6000[4:2]) begin
            banks_next[bank_wr.address[12:11]] = v;
          end
        end
        MT_ASC16: begin
          // Each 16K page spans two 8K windows: load v*2 and v*2+1
          if (slot == SLOT_6000) begin
            banks_next[0] = {v[6:0], 1'b0};
            banks_next[1] = {v[6:0], 1'b1};
          end else if (slot == SLOT_7000) begin
            banks_next[2] = {v[6:0], 1'b0};
            banks_next[3] = {v[6:0], 1'b1};
          end
        end
        MT_KONSCC: begin
          if (slot == SLOT_5000) begin
            banks_next[0] = v;
          end else if (slot == SLOT_7000) begin
            banks_next[1] = v;
          end else if (slot == SLOT_9000) begin
            banks_next[2] = v;
          end else if (slot == SLOT_B000) begin
            banks_next[3] = v;
          end
        end
        default: begin
          banks_next = banks;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      banks <= '0;
    end else begin
      banks <= banks_next;
    end
  end

endmodule

`default_nettype wire

### src/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartridge bank mapper for a 64K CPU address space.
//
// Command channel: present a word on cmd and raise start; it is taken at a
// rising edge where start is high and busy is low. A bus write (mode 1)
// loads bank registers per the mapper type and yields no result; busy stays
// low, so the next word can follow in the next cycle.
// A read (mode 0) yields one result word on result, marked by result_valid
// for exactly one cycle. A plain-type read is registered once: result_valid
// rises in the cycle after the accepting edge. A banked read goes through
// the single one-bit-per-cycle remainder unit (bank mod bank count) and then
// the output register. busy is high while the remainder is worked out, so
// the next word is taken at the edge that takes the result; no new word is
// taken while a banked read is still in progress.
// The receiver cannot stall: each result is taken the cycle it shows, and a
// new word may be accepted while the previous result is on the port.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Index 0 sets mapper_type and reloads its default banks;
// index 1 sets rom_size. Write these only while the block is idle.
// Reset (rst, synchronous) sets plain type, a 32K ROM, all banks zero, and
// clears busy and result_valid.
module cartridge_bank_mapper (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire cbm_pkg::cmd_t                     cmd,
  output logic                                   result_valid,
  output cbm_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [cbm_pkg::ROM_SIZE_W-1:0]    cfg_data
);
  import cbm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_MOD  = 1'b1;

  logic                    state;
  logic [TYPE_W-1:0]       mapper_type;
  logic [ROM_SIZE_W-1:0]   rom_size;
  logic [12:0]             offset;

  logic                    accept;
  logic                    cfg_write;
  bank_wr_t                bank_wr;
  type_load_t              type_load;
  bank_file_t              banks;

  logic [2:0]              win;
  logic [BANK_W-1:0]       sel_bank;
  logic [BANK_COUNT_W-1:0] bank_count;
  logic [15:0]             plain_off;
  logic                    plain_open;
  logic                    mod_start;
  logic                    mod_done;
  logic [BANK_W-1:0]       mod_rem;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = (state == S_MOD);
  assign accept    = start && !busy;

  // Take the bus write straight into the bank registers
  assign bank_wr = '{en:      accept && (cmd.mode == MODE_WRITE),
                     address: cmd.address,
                     data:    cmd.write_data};

  assign type_load = '{en:          cfg_write && (cfg_index == CFG_MAPPER_TYPE),
                       mapper_type: cfg_data[TYPE_W-1:0]};

  cbm_bank_regs u_bank_regs (
    .clk         (clk),
    .rst         (rst),
    .mapper_type (mapper_type),
    .bank_wr     (bank_wr),
    .type_load   (type_load),
    .banks       (banks)
  );

  // Windows outside 0x4000-0xBFFF always see bank 0
  assign win = cmd.address[15:13];
  always_comb begin
    if (win >= WIN_FIRST_BANKED && win <= WIN_LAST_BANKED) begin
      sel_bank = banks[2'(win - WIN_FIRST_BANKED)];
    end else begin
      sel_bank = '0;
    end
  end

  // Count of 8K banks, never below one
  always_comb begin
    bank_count = rom_size[ROM_SIZE_W-1:13];
    if (bank_count == '0) begin
      bank_count = BANK_COUNT_W'(1);
    end
  end

  // Plain type: direct map from 0x4000, open bus below it or past the ROM
  assign plain_off  = cmd.address - PLAIN_BASE;
  assign plain_open = (cmd.address < PLAIN_BASE) ||
                      (ROM_SIZE_W'(plain_off) >= rom_size);

  assign mod_start = accept && (cmd.mode == MODE_READ) && (mapper_type != MT_FLAT);

  cbm_mod_unit u_mod_unit (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (sel_bank),
    .divisor   (bank_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_type <= MT_FLAT;
      rom_size    <= ROM_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAPPER_TYPE: mapper_type <= cfg_data[TYPE_W-1:0];
        CFG_ROM_SIZE:    rom_size    <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Sequencer and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (mod_start) begin
            state <= S_MOD;
          end else if (accept && cmd.mode == MODE_READ) begin
            result_valid <= 1'b1;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the in-window offset while the remainder is worked out
  always_ff @(posedge clk) begin
    if (mod_start) begin
      offset <= cmd.address[12:0];
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (state == S_MOD && mod_done) begin
      result.rom_address <= fit_rom_addr({mod_rem, offset});
      result.open_bus    <= 1'b0;
    end else if (accept && cmd.mode == MODE_READ && mapper_type == MT_FLAT) begin
      if (plain_open) begin
        result.rom_address <= '0;
        result.open_bus    <= 1'b1;
      end else begin
        result.rom_address <= fit_rom_addr(FULL_ADDR_W'(plain_off));
        result.open_bus    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
